// ----- src/spv_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constant tables of the sampler voice.
package spv_pkg;

   // Item function codes.
   localparam logic [1:0] FUNC_LOAD     = 2'd0;
   localparam logic [1:0] FUNC_NOTE_ON  = 2'd1;
   localparam logic [1:0] FUNC_NOTE_OFF = 2'd2;
   localparam logic [1:0] FUNC_TICK     = 2'd3;

   // Configuration register indexes.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_NOTE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_LOW       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_HIGH      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_RATIO    = 3'd5;

   localparam logic [4:0]  RAMP_STEPS = 5'd20;
   localparam logic [16:0] UNITY_Q16  = 17'd65536;
   localparam logic [15:0] DECAY_Q16  = 16'd65484;
   localparam logic [16:0] STOP_Q16   = 17'd66;

   typedef struct packed {
      logic [1:0]         func;
      logic [15:0]        load_addr;
      logic signed [15:0] load_left;
      logic signed [15:0] load_right;
      logic [6:0]         note;
      logic [6:0]         velocity;
      logic               tail_off;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic               voice_active;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic mul;
   } pitch_ctl_type;

   typedef struct packed {
      logic capture;
      logic stereo;
   } mix_ctl_type;

   // 2^(k/12) in Q1.16, rounded to nearest.
   function automatic logic [16:0] semitone_factor(logic [3:0] semi);
      logic [16:0] f;
      case (semi)
         4'd0:    f = 17'd65536;
         4'd1:    f = 17'd69433;
         4'd2:    f = 17'd73562;
         4'd3:    f = 17'd77936;
         4'd4:    f = 17'd82570;
         4'd5:    f = 17'd87480;
         4'd6:    f = 17'd92682;
         4'd7:    f = 17'd98193;
         4'd8:    f = 17'd104032;
         4'd9:    f = 17'd110218;
         4'd10:   f = 17'd116772;
         4'd11:   f = 17'd123715;
         default: f = 17'd65536;
      endcase
      return f;
   endfunction

   // Attack gain floor(k * 65536 / 20) in Q1.16.
   function automatic logic [16:0] attack_gain(logic [4:0] k);
      logic [16:0] g;
      case (k)
         5'd0:    g = 17'd0;
         5'd1:    g = 17'd3276;
         5'd2:    g = 17'd6553;
         5'd3:    g = 17'd9830;
         5'd4:    g = 17'd13107;
         5'd5:    g = 17'd16384;
         5'd6:    g = 17'd19660;
         5'd7:    g = 17'd22937;
         5'd8:    g = 17'd26214;
         5'd9:    g = 17'd29491;
         5'd10:   g = 17'd32768;
         5'd11:   g = 17'd36044;
         5'd12:   g = 17'd39321;
         5'd13:   g = 17'd42598;
         5'd14:   g = 17'd45875;
         5'd15:   g = 17'd49152;
         5'd16:   g = 17'd52428;
         5'd17:   g = 17'd55705;
         5'd18:   g = 17'd58982;
         5'd19:   g = 17'd62259;
         5'd20:   g = 17'd65536;
         default: g = 17'd0;
      endcase
      return g;
   endfunction

endpackage

// ----- src/spv_sample_store.sv -----
`timescale 1ns / 1ps
// Stereo sample memory: one write port, two registered read ports.
module spv_sample_store #(
   parameter int SAMPLE_DEPTH = 65536,
   parameter int ADDR_W       = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic signed [15:0]       wr_left,
   input  logic signed [15:0]       wr_right,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr0,
   input  logic [ADDR_W-1:0]        rd_addr1,
   output logic signed [15:0]       rd_left0,
   output logic signed [15:0]       rd_left1,
   output logic signed [15:0]       rd_right0,
   output logic signed [15:0]       rd_right1
);

   logic signed [15:0] left_mem  [SAMPLE_DEPTH];
   logic signed [15:0] right_mem [SAMPLE_DEPTH];

   logic signed [15:0] rd_left0_ff, rd_left1_ff, rd_right0_ff, rd_right1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_mem[wr_addr]  <= wr_left;
         right_mem[wr_addr] <= wr_right;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_left0_ff  <= left_mem[rd_addr0];
         rd_left1_ff  <= left_mem[rd_addr1];
         rd_right0_ff <= right_mem[rd_addr0];
         rd_right1_ff <= right_mem[rd_addr1];
      end
   end

   assign rd_left0  = rd_left0_ff;
   assign rd_left1  = rd_left1_ff;
   assign rd_right0 = rd_right0_ff;
   assign rd_right1 = rd_right1_ff;

endmodule

// ----- src/spv_pitch_unit.sv -----
`timescale 1ns / 1ps
// Note-on step calculation: semitone split, rate multiply, octave shift.
module spv_pitch_unit (
   input  logic                  clock,
   input  spv_pkg::pitch_ctl_type ctl,
   input  logic [6:0]            note,
   input  logic [6:0]            root_note,
   input  logic [17:0]           rate_ratio,
   output logic [31:0]           step
);
   import spv_pkg::*;

   logic [8:0]  ofs_note;
   logic [18:0] quot_prod;
   logic [4:0]  quot;
   logic [8:0]  quot_x12;
   logic [3:0]  semi_in;
   logic [4:0]  shamt_in;
   logic [3:0]  semi_ff;
   logic [4:0]  shamt_ff;
   logic [34:0] prod_in;
   logic [34:0] prod_ff;
   logic [45:0] shifted;
   logic [46:0] rounded;

   // Offset by eleven octaves so the split works on a non-negative value;
   // the quotient by 12 is a reciprocal multiply, exact for this range.
   always_comb begin
      ofs_note  = {2'b00, note} + 9'd132 - {2'b00, root_note};
      quot_prod = {10'b0, ofs_note} * 19'd1366;
      quot      = quot_prod[18:14];
      quot_x12  = {1'b0, quot, 3'b000} + {2'b00, quot, 2'b00};
      semi_in   = 4'(ofs_note - quot_x12);
      // Octave shift of (quot - 11) applied to the product scaled by 2^11.
      shamt_in  = 5'd22 - quot;
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         semi_ff  <= semi_in;
         shamt_ff <= shamt_in;
      end
   end

   assign prod_in = {17'b0, rate_ratio} * {18'b0, semitone_factor(semi_ff)};

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         prod_ff <= prod_in;
      end
   end

   // The shifted product stays below 2^45, so the rounded step always fits
   // in 32 bits and never needs saturation.
   always_comb begin
      shifted = {prod_ff, 11'b0} >> shamt_ff;
      rounded = {1'b0, shifted} + 47'd32768;
      step    = 32'(rounded[46:16]);
   end

endmodule

// ----- src/spv_mix_path.sv -----
`timescale 1ns / 1ps
// Interpolation and gain datapath of the voice, registered between the interpolation and the gain multiply.
module spv_mix_path #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                 clock,
   input  spv_pkg::mix_ctl_type ctl,
   input  logic signed [15:0]   left0,
   input  logic signed [15:0]   left1,
   input  logic signed [15:0]   right0,
   input  logic signed [15:0]   right1,
   input  logic [15:0]          frac,
   input  logic [4:0]           ramp,
   input  logic [16:0]          release_gain,
   output logic signed [15:0]   left_q,
   output logic signed [15:0]   right_q
);
   import spv_pkg::*;

   localparam int OUT_BITS  = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
   localparam int CLAMP_HI  = (1 << (OUT_BITS - 1)) - 1;
   localparam int CLAMP_MAG = 1 << (OUT_BITS - 1);

   logic signed [15:0] sl_in, sr_in, sl_ff, sr_ff;
   logic [33:0]        gain_prod;
   logic [16:0]        gain_in, gain_ff;

   // a + (b - a) * f on offset-binary samples, rounded half up.
   function automatic logic signed [15:0] interp(logic signed [15:0] a,
                                                 logic signed [15:0] b,
                                                 logic [15:0] f);
      logic [15:0]        ua, ub, v;
      logic signed [16:0] diff;
      logic signed [33:0] prod;
      logic signed [34:0] sum;
      ua   = {~a[15], a[14:0]};
      ub   = {~b[15], b[14:0]};
      diff = $signed({1'b0, ub}) - $signed({1'b0, ua});
      prod = diff * $signed({1'b0, f});
      sum  = $signed({3'b000, ua, 16'b0}) + 35'(prod) + 35'sd32768;
      v    = sum[31:16];
      return {~v[15], v[14:0]};
   endfunction

   // Magnitude times gain, rounded half away from zero, then clamped.
   function automatic logic signed [15:0] apply_gain(logic signed [15:0] s,
                                                     logic [16:0] g);
      logic [15:0] mag;
      logic [32:0] prod;
      logic [17:0] r;
      logic [17:0] neg;
      logic [15:0] res;
      mag  = s[15] ? (~s + 16'd1) : s;
      prod = {1'b0, mag} * {16'b0, g};
      r    = 18'((prod + 33'd32768) >> 16);
      neg  = ~r + 18'd1;
      if (!s[15]) begin
         res = (r > 18'(CLAMP_HI)) ? 16'(CLAMP_HI) : r[15:0];
      end else begin
         res = (r > 18'(CLAMP_MAG)) ? 16'(-CLAMP_MAG) : neg[15:0];
      end
      return res;
   endfunction

   always_comb begin
      sl_in     = interp(left0, left1, frac);
      sr_in     = ctl.stereo ? interp(right0, right1, frac) : sl_in;
      gain_prod = {17'b0, attack_gain(ramp)} * {17'b0, release_gain};
      gain_in   = gain_prod[32:16];
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         sl_ff   <= sl_in;
         sr_ff   <= sr_in;
         gain_ff <= gain_in;
      end
   end

   assign left_q  = apply_gain(sl_ff, gain_ff);
   assign right_q = apply_gain(sr_ff, gain_ff);

endmodule

// ----- src/sample_playback_voice_core.sv -----
`timescale 1ns / 1ps
// Top level of the sampler voice: control sequencer, voice state and ports.
//
//   channel   ports                                   direction
//   request   req_valid, req_ready, req_data          in  (load, note on/off, tick)
//   response  rsp_valid, rsp_ready, rsp_data          out (one item per tick)
//   config    csr_wr_en, csr_index, csr_wdata         in  (write only, no wait)
//
// Load and note-off items finish in the state that accepts them, as does a note-on
// outside the velocity window; a note-on inside it passes through the split, the rate
// multiply and the octave shift. A tick passes through the sample memory read,
// interpolation with the gain product, then the gain multiply into the output
// register. A tick waits in its last cycle while an earlier item still sits unclaimed
// in the output register. The sample memory needs no clearing pass after the
// synchronous reset.
module sample_playback_voice_core #(
   parameter int SAMPLE_DEPTH = 65536,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  spv_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output spv_pkg::rsp_type                    rsp_data,
   input  logic                                csr_wr_en,
   input  logic [spv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [spv_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import spv_pkg::*;

   localparam int ADDR_W = $clog2(SAMPLE_DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE        = 5'b00001,
      ST_PITCH_MUL   = 5'b00010,
      ST_PITCH_SHIFT = 5'b00100,
      ST_MIX_INTERP  = 5'b01000,
      ST_MIX_GAIN    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [16:0] sample_length_ff;
   logic        stereo_ff;
   logic [6:0]  root_note_ff, vel_low_ff, vel_high_ff;
   logic [17:0] rate_ratio_ff;

   logic [31:0] position_ff, position_in;
   logic [31:0] step_ff, step_in;
   logic [4:0]  ramp_ff, ramp_in;
   logic [16:0] release_ff, release_in;
   logic        releasing_ff, releasing_in;
   logic        playing_ff, playing_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        audible_ff, audible_in;
   logic [15:0] frac_ff;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic          accept, is_load, is_note_on, is_note_off, is_tick;
   logic          in_window, at_end, rsp_free;
   logic [31:0]   len, idx32, idx_next, addr32;
   logic [4:0]    ramp_next;
   logic [32:0]   decay_prod;
   logic [16:0]   decay;
   logic [32:0]   pos_sum;
   logic [31:0]   pos_sat;
   logic [31:0]   pitch_step;
   logic signed [15:0] left0, left1, right0, right1, left_q, right_q;
   pitch_ctl_type pitch_ctl;
   mix_ctl_type   mix_ctl;

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign is_load     = accept && (req_data.func == FUNC_LOAD);
   assign is_note_on  = accept && (req_data.func == FUNC_NOTE_ON);
   assign is_note_off = accept && (req_data.func == FUNC_NOTE_OFF);
   assign is_tick     = accept && (req_data.func == FUNC_TICK);
   assign rsp_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      len = ({15'b0, sample_length_ff} < 32'(SAMPLE_DEPTH)) ?
            {15'b0, sample_length_ff} : 32'(SAMPLE_DEPTH);
      idx32      = {16'b0, position_ff[31:16]};
      idx_next   = idx32 + 32'd1;
      at_end     = (idx_next >= len);
      addr32     = {16'b0, req_data.load_addr};
      in_window  = (req_data.velocity >= vel_low_ff) && (req_data.velocity <= vel_high_ff);
      ramp_next  = (ramp_ff < RAMP_STEPS) ? ramp_ff + 5'd1 : ramp_ff;
      decay_prod = {16'b0, release_ff} * {17'b0, DECAY_Q16};
      decay      = decay_prod[32:16];
      pos_sum    = {1'b0, position_ff} + {1'b0, step_ff};
      pos_sat    = pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];
   end

   spv_sample_store #(
      .SAMPLE_DEPTH(SAMPLE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_store (
      .clock    (clock),
      .wr_en    (is_load && (addr32 < 32'(SAMPLE_DEPTH))),
      .wr_addr  (addr32[ADDR_W-1:0]),
      .wr_left  (req_data.load_left),
      .wr_right (req_data.load_right),
      .rd_en    (is_tick),
      .rd_addr0 (idx32[ADDR_W-1:0]),
      .rd_addr1 (idx_next[ADDR_W-1:0]),
      .rd_left0 (left0),
      .rd_left1 (left1),
      .rd_right0(right0),
      .rd_right1(right1)
   );

   assign pitch_ctl.start = is_note_on && in_window;
   assign pitch_ctl.mul   = (state_ff == ST_PITCH_MUL);

   spv_pitch_unit u_pitch (
      .clock     (clock),
      .ctl       (pitch_ctl),
      .note      (req_data.note),
      .root_note (root_note_ff),
      .rate_ratio(rate_ratio_ff),
      .step      (pitch_step)
   );

   assign mix_ctl.capture = (state_ff == ST_MIX_INTERP);
   assign mix_ctl.stereo  = stereo_ff;

   spv_mix_path #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_mix (
      .clock       (clock),
      .ctl         (mix_ctl),
      .left0       (left0),
      .left1       (left1),
      .right0      (right0),
      .right1      (right1),
      .frac        (frac_ff),
      .ramp        (ramp_ff),
      .release_gain(release_ff),
      .left_q      (left_q),
      .right_q     (right_q)
   );

   always_comb begin
      state_in     = state_ff;
      position_in  = position_ff;
      step_in      = step_ff;
      ramp_in      = ramp_ff;
      release_in   = release_ff;
      releasing_in = releasing_ff;
      playing_in   = playing_ff;
      audible_in   = audible_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (is_note_on) begin
               if (in_window) begin
                  position_in  = 32'd0;
                  ramp_in      = 5'd0;
                  release_in   = UNITY_Q16;
                  releasing_in = 1'b0;
                  playing_in   = 1'b1;
                  state_in     = ST_PITCH_MUL;
               end else begin
                  playing_in = 1'b0;
               end
            end else if (is_note_off) begin
               if (req_data.tail_off) begin
                  releasing_in = 1'b1;
               end else begin
                  playing_in  = 1'b0;
                  position_in = 32'd0;
               end
            end else if (is_tick) begin
               state_in   = ST_MIX_INTERP;
               audible_in = 1'b0;
               if (playing_ff) begin
                  if (at_end) begin
                     playing_in = 1'b0;
                  end else begin
                     ramp_in = ramp_next;
                     if (releasing_ff) begin
                        release_in = decay;
                     end
                     // A release that decays below the floor silences this tick.
                     if (releasing_ff && (decay < STOP_Q16)) begin
                        playing_in = 1'b0;
                     end else begin
                        audible_in  = 1'b1;
                        position_in = pos_sat;
                     end
                  end
               end
            end
         end
         ST_PITCH_MUL: begin
            state_in = ST_PITCH_SHIFT;
         end
         ST_PITCH_SHIFT: begin
            step_in  = pitch_step;
            state_in = ST_IDLE;
         end
         ST_MIX_INTERP: begin
            state_in = ST_MIX_GAIN;
         end
         ST_MIX_GAIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (audible_ff) begin
                  rsp_data_in.left_out     = left_q;
                  rsp_data_in.right_out    = right_q;
                  rsp_data_in.voice_active = 1'b1;
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         position_ff  <= 32'd0;
         step_ff      <= {15'b0, UNITY_Q16};
         ramp_ff      <= 5'd0;
         release_ff   <= UNITY_Q16;
         releasing_ff <= 1'b0;
         playing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         position_ff  <= position_in;
         step_ff      <= step_in;
         ramp_ff      <= ramp_in;
         release_ff   <= release_in;
         releasing_ff <= releasing_in;
         playing_ff   <= playing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      audible_ff  <= audible_in;
      rsp_data_ff <= rsp_data_in;
      if (is_tick) begin
         frac_ff <= position_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_length_ff <= 17'd2;
         stereo_ff        <= 1'b1;
         root_note_ff     <= 7'd60;
         vel_low_ff       <= 7'd0;
         vel_high_ff      <= 7'd127;
         rate_ratio_ff    <= 18'd65536;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SAMPLE_LENGTH: sample_length_ff <= {1'b0, csr_wdata[15:0]} |
                                                   {csr_wdata[16], 16'b0};
            CSR_STEREO:        stereo_ff        <= csr_wdata[0];
            CSR_ROOT_NOTE:     root_note_ff     <= csr_wdata[6:0];
            CSR_VEL_LOW:       vel_low_ff       <= csr_wdata[6:0];
            CSR_VEL_HIGH:      vel_high_ff      <= csr_wdata[6:0];
            CSR_RATE_RATIO:    rate_ratio_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_ramp_bound: assert property (@(posedge clock) disable iff (reset)
      ramp_ff <= RAMP_STEPS)
      else $error("attack ramp beyond its last step");

   a_release_bound: assert property (@(posedge clock) disable iff (reset)
      release_ff <= UNITY_Q16)
      else $error("release gain above unity");

   a_tick_sequence: assert property (@(posedge clock) disable iff (reset)
      is_tick |=> (state_ff == ST_MIX_INTERP) ##1 (state_ff == ST_MIX_GAIN))
      else $error("tick item left the mix sequence");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX_GAIN) && rsp_valid_ff && !rsp_ready
      |=> (state_ff == ST_MIX_GAIN))
      else $error("result loaded over an unclaimed item");

   a_silent_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.voice_active
      |-> (rsp_data_ff.left_out == 16'sd0) && (rsp_data_ff.right_out == 16'sd0))
      else $error("inactive voice produced sound");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the sampler voice: stimulus, prediction and output checks.
module testbench;
   import spv_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int FULL_RAMP     = 20;
   localparam int DECAY_MUL     = 65484;
   localparam int SILENCE_FLOOR = 66;
   localparam int STORE_DEPTH   = 65536;

   typedef enum {END_NONE, END_RELEASE, END_CUT} phrase_end_type;

   class voice_scoreboard;
      bit [16:0]          len_reg;
      bit                 stereo_reg;
      bit [6:0]           root_reg;
      bit [6:0]           vel_lo;
      bit [6:0]           vel_hi;
      bit [17:0]          rate_reg;
      bit [31:0]          position;
      bit [31:0]          step;
      bit [4:0]           ramp;
      bit [16:0]          rel_gain;
      bit                 releasing;
      bit                 playing;
      logic signed [15:0] left_mem [STORE_DEPTH];
      logic signed [15:0] right_mem [STORE_DEPTH];
      bit                 written [STORE_DEPTH];
      int unsigned        semi_q16 [12];
      rsp_type            expected_samples [$];
      int                 errors;

      function new();
         semi_q16 = '{65536, 69433, 73562, 77936, 82570, 87480,
                      92682, 98193, 104032, 110218, 116772, 123715};
         len_reg    = 17'd2;
         stereo_reg = 1'b1;
         root_reg   = 7'd60;
         vel_lo     = 7'd0;
         vel_hi     = 7'd127;
         rate_reg   = 18'd65536;
         position   = '0;
         step       = 32'd65536;
         ramp       = '0;
         rel_gain   = 17'd65536;
         releasing  = 1'b0;
         playing    = 1'b0;
         errors     = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned value);
         case (idx)
            CSR_SAMPLE_LENGTH: len_reg    = value[16:0];
            CSR_STEREO:        stereo_reg = value[0];
            CSR_ROOT_NOTE:     root_reg   = value[6:0];
            CSR_VEL_LOW:       vel_lo     = value[6:0];
            CSR_VEL_HIGH:      vel_hi     = value[6:0];
            CSR_RATE_RATIO:    rate_reg   = value[17:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction

      function int unsigned usable_length();
         return (len_reg < STORE_DEPTH) ? int'(len_reg) : STORE_DEPTH;
      endfunction

      // Address that the next tick would read before anything was loaded there, or -1.
      function int missing_sample();
         int unsigned idx;
         idx = position[31:16];
         if (!playing || idx + 1 >= usable_length())
            return -1;
         if (!written[idx])
            return int'(idx);
         if (!written[idx + 1])
            return int'(idx + 1);
         return -1;
      endfunction

      function bit [31:0] pitch_step(bit [6:0] note);
         int       diff;
         int       semi;
         int       oct;
         bit [63:0] v;
         diff = int'(note) - int'(root_reg);
         semi = ((diff % 12) + 12) % 12;
         oct  = (diff - semi) / 12;
         v = 64'(rate_reg) * 64'(semi_q16[semi]);
         if (oct >= 0)
            v = v << oct;
         else
            v = v >> (-oct);
         v = (v + 64'd32768) >> 16;
         return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
      endfunction

      // Interpolation works on offset-binary samples so the rounding is half up.
      function int blend(int a, int b, int frac);
         longint ua;
         longint ub;
         longint v;
         ua = longint'(a) + 32768;
         ub = longint'(b) + 32768;
         v = (ua * (65536 - frac) + ub * frac + 32768) >>> 16;
         return int'(v) - 32768;
      endfunction

      function logic signed [15:0] scale(int s, longint g);
         longint mag;
         longint r;
         mag = (s < 0) ? -longint'(s) : longint'(s);
         r = (mag * g + 32768) >>> 16;
         if (s < 0)
            r = -r;
         if (r < -32768)
            r = -32768;
         if (r > 32767)
            r = 32767;
         return 16'(r);
      endfunction

      function void predict_tick();
         int unsigned idx;
         int          frac;
         int          sl;
         int          sr;
         longint      g;
         bit [32:0]   next;
         rsp_type     e;
         e = '0;
         idx  = position[31:16];
         frac = int'(position[15:0]);
         if (playing) begin
            if (idx + 1 >= usable_length()) begin
               playing = 1'b0;
            end else begin
               sl = blend(left_mem[idx], left_mem[idx + 1], frac);
               sr = stereo_reg ? blend(right_mem[idx], right_mem[idx + 1], frac) : sl;
               if (ramp < FULL_RAMP)
                  ramp++;
               if (releasing) begin
                  rel_gain = 17'((64'(rel_gain) * DECAY_MUL) >> 16);
                  if (rel_gain < SILENCE_FLOOR)
                     playing = 1'b0;
               end
               if (playing) begin
                  g = ((longint'(ramp) * 65536 / FULL_RAMP) * longint'(rel_gain)) >>> 16;
                  e.left_out     = scale(sl, g);
                  e.right_out    = scale(sr, g);
                  e.voice_active = 1'b1;
                  next = 33'(position) + 33'(step);
                  position = next[32] ? 32'hFFFF_FFFF : next[31:0];
               end
            end
         end
         expected_samples.push_back(e);
      endfunction

      function void note_request(req_type r);
         case (r.func)
            FUNC_LOAD: begin
               left_mem[r.load_addr]  = r.load_left;
               right_mem[r.load_addr] = r.load_right;
               written[r.load_addr]   = 1'b1;
            end
            FUNC_NOTE_ON: begin
               if (r.velocity < vel_lo || r.velocity > vel_hi) begin
                  playing = 1'b0;
               end else begin
                  step      = pitch_step(r.note);
                  position  = '0;
                  ramp      = '0;
                  rel_gain  = 17'd65536;
                  releasing = 1'b0;
                  playing   = 1'b1;
               end
            end
            FUNC_NOTE_OFF: begin
               if (r.tail_off) begin
                  releasing = 1'b1;
               end else begin
                  playing  = 1'b0;
                  position = '0;
               end
            end
            default: predict_tick();
         endcase
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= 10)
            $display("%s", what);
      endfunction

      function void check_sample(rsp_type got);
         rsp_type want;
         if (expected_samples.size() == 0) begin
            flag($sformatf("unexpected output item: L=%0d R=%0d active=%0b",
                           got.left_out, got.right_out, got.voice_active));
            return;
         end
         want = expected_samples.pop_front();
         if (got.left_out !== want.left_out || got.right_out !== want.right_out ||
             got.voice_active !== want.voice_active)
            flag($sformatf("output mismatch: expected L=%0d R=%0d active=%0b, got L=%0d R=%0d active=%0b",
                           want.left_out, want.right_out, want.voice_active,
                           got.left_out, got.right_out, got.voice_active));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic            hold_off = 1'b0;
   logic            idle_on = 1'b1;
   int              items_sent = 0;
   int              cycles = 0;
   voice_scoreboard sb;

   sample_playback_voice_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Output side: check what was taken at this edge, then pick the next ready level.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_sample(rsp_data);
         rsp_ready <= !(hold_off || (idle_on && $urandom_range(0, 99) < 11));
      end
   end

   // One long output stall so the voice backs up into its input, then a stretch
   // without any random idling on either side.
   initial begin
      wait (items_sent >= 300);
      hold_off <= 1'b1;
      repeat (400) @(posedge clock);
      hold_off <= 1'b0;
      wait (items_sent >= 700);
      idle_on <= 1'b0;
      wait (items_sent >= 950);
      idle_on <= 1'b1;
   end

   function automatic req_type random_item();
      req_type r;
      r.func       = 2'($urandom_range(0, 3));
      r.load_addr  = 16'($urandom_range(0, 65535));
      r.load_left  = 16'($urandom_range(0, 65535));
      r.load_right = 16'($urandom_range(0, 65535));
      r.note       = 7'($urandom_range(0, 127));
      r.velocity   = 7'($urandom_range(0, 127));
      r.tail_off   = 1'($urandom_range(0, 1));
      return r;
   endfunction

   task automatic send_item(input req_type r);
      while (idle_on && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      sb.note_request(r);
   endtask

   task automatic send_load(input logic [15:0] addr, input logic [15:0] l, input logic [15:0] r);
      req_type item;
      item = random_item();
      item.func       = FUNC_LOAD;
      item.load_addr  = addr;
      item.load_left  = l;
      item.load_right = r;
      send_item(item);
   endtask

   // Fills any store entry the coming tick would read, so no unwritten sample is played.
   task automatic send_tick();
      req_type item;
      int      addr;
      addr = sb.missing_sample();
      while (addr >= 0) begin
         send_load(16'(addr), 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
         addr = sb.missing_sample();
      end
      item = random_item();
      item.func = FUNC_TICK;
      send_item(item);
   endtask

   task automatic send_note_off(input logic tail);
      req_type item;
      item = random_item();
      item.func     = FUNC_NOTE_OFF;
      item.tail_off = tail;
      send_item(item);
   endtask

   task automatic play_phrase(input logic [6:0] note, input logic [6:0] vel, input int ticks,
                              input phrase_end_type ending, input int tail_ticks);
      req_type item;
      item = random_item();
      item.func     = FUNC_NOTE_ON;
      item.note     = note;
      item.velocity = vel;
      send_item(item);
      repeat (ticks) send_tick();
      if (ending != END_NONE) begin
         send_note_off(ending == END_RELEASE);
         repeat (tail_ticks) send_tick();
      end
   endtask

   task automatic random_traffic(input int count);
      int             stop_at;
      int             n;
      int             k;
      int             v;
      phrase_end_type ending;
      req_type        item;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, 24);
            n = ($urandom_range(0, 2) != 0) ? int'(sb.root_reg) + k - 12
                                            : int'($urandom_range(0, 127));
            if (n < 0)
               n = 0;
            if (n > 127)
               n = 127;
            if (sb.vel_lo <= sb.vel_hi)
               v = $urandom_range(sb.vel_hi, sb.vel_lo);
            else
               v = $urandom_range(0, 127);
            case ($urandom_range(0, 4))
               2, 3:    ending = END_RELEASE;
               4:       ending = END_CUT;
               default: ending = END_NONE;
            endcase
            play_phrase(7'(n), 7'(v), $urandom_range(1, 24), ending, $urandom_range(0, 12));
         end else begin
            item = random_item();
            if (item.func == FUNC_TICK) begin
               send_tick();
            end else begin
               if (item.func == FUNC_LOAD && $urandom_range(0, 1) == 0)
                  item.load_addr = 16'($urandom_range(0, 63));
               send_item(item);
            end
         end
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      // A note-on or load leaves no output behind, so give the core time to finish it.
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic set_voice(input int unsigned len, input int unsigned st, input int unsigned root,
                            input int unsigned lo, input int unsigned hi, input int unsigned rate);
      settle();
      write_csr(CSR_SAMPLE_LENGTH, len);
      write_csr(CSR_STEREO, st);
      write_csr(CSR_ROOT_NOTE, root);
      write_csr(CSR_VEL_LOW, lo);
      write_csr(CSR_VEL_HIGH, hi);
      write_csr(CSR_RATE_RATIO, rate);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int unsigned c_len;
      int unsigned c_lo;
      int unsigned c_hi;
      int unsigned c_tmp;
      int unsigned c_rate;

      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Reset settings: a two-sample stereo store at unity pitch.
      send_tick();
      send_load(16'd0, 16'h7FFF, 16'h8000);
      send_load(16'd1, 16'h8000, 16'h7FFF);
      send_load(16'hFFFF, 16'hFFFF, 16'h0000);
      play_phrase(7'd60, 7'd127, 3, END_NONE, 0);
      send_note_off(1'b1);
      send_tick();
      play_phrase(7'd127, 7'd0, 1, END_CUT, 1);
      play_phrase(7'd0, 7'd64, 2, END_RELEASE, 1);
      play_phrase(7'd60, 7'd1, 0, END_NONE, 0);
      play_phrase(7'd72, 7'd127, 1, END_NONE, 0);

      set_voice(16, 1, 60, 0, 127, 65536);
      random_traffic(130);
      set_voice(2, 0, 0, 64, 64, 262143);
      random_traffic(130);
      // Widest pitch over the full store, so the position saturates before the end.
      set_voice(65536, 1, 0, 0, 127, 262143);
      play_phrase(7'd127, 7'd100, 12, END_NONE, 0);
      random_traffic(130);
      set_voice(0, 1, 60, 100, 50, 65536);
      random_traffic(60);
      set_voice(1, 0, 127, 0, 127, 0);
      random_traffic(60);

      repeat (7) begin
         case ($urandom_range(0, 9))
            0:       c_len = 65536;
            1:       c_len = $urandom_range(2, 65536);
            default: c_len = $urandom_range(2, 40);
         endcase
         c_lo = $urandom_range(0, 127);
         c_hi = $urandom_range(0, 127);
         if (c_lo > c_hi && $urandom_range(0, 3) != 0) begin
            c_tmp = c_lo;
            c_lo  = c_hi;
            c_hi  = c_tmp;
         end
         case ($urandom_range(0, 5))
            0:       c_rate = 0;
            1:       c_rate = 262143;
            default: c_rate = $urandom_range(8192, 131072);
         endcase
         set_voice(c_len, $urandom_range(0, 1), $urandom_range(0, 127), c_lo, c_hi, c_rate);
         random_traffic(130);
      end

      // A held position keeps the voice sounding while its release fades.
      set_voice(4, 0, 60, 0, 127, 0);
      play_phrase(7'd67, 7'd90, 4, END_RELEASE, 40);
      repeat (3) send_tick();

      settle();
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- files.f -----
src/spv_pkg.sv
src/spv_sample_store.sv
src/spv_pitch_unit.sv
src/spv_mix_path.sv
src/sample_playback_voice_core.sv
sim/testbench.sv
